// ----- design/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, codes and constants of the differential-drive odometry core.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  // data word of the shared multiply / divide unit
  localparam int WORD_W = 64;

  // cordic datapath width and table depth
  localparam int CD_W       = 34;
  localparam int CD_MAX     = 24;
  localparam int CD_IDX_W   = 5;
  localparam logic signed [CD_W-1:0] CD_GAIN_Q30 = 34'sd652032874;

  // rounded heading sine / cosine width (Q20 plus headroom)
  localparam int TRIG_W = 24;

  // radians Q24 to 32-bit binary angle
  localparam logic signed [WORD_W-1:0] RAD24_TO_BAM32 = 64'sd683565276;

  // reciprocals for the series divides by 6 and 24, exact for the
  // non-negative operand ranges of the small-turn branch
  localparam logic signed [WORD_W-1:0] RCP_DIV6  = 64'sd43691;
  localparam logic signed [WORD_W-1:0] RCP_DIV24 = 64'sd10923;
  localparam int                       RCP_SHIFT = 18;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MPT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MPT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE = 2'd2;

  localparam logic [31:0] LEFT_MPT_RST   = 32'd366325;
  localparam logic [31:0] RIGHT_MPT_RST  = 32'd366325;
  localparam logic [15:0] WHEEL_BASE_RST = 16'd15073;

  typedef enum logic {
    MD_OP_MUL,
    MD_OP_DIV
  } ddo_md_op_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIX
  } ddo_md_state_e;

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_RUN,
    CD_FIX,
    CD_DONE
  } ddo_cd_state_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_DL,
    S_MUL_DR,
    S_DIV_Q,
    S_MUL_ANG,
    S_MUL_Q2,
    S_MUL_CUBE,
    S_MUL_F6,
    S_MUL_G24,
    S_CRD_ARC,
    S_DIV_FA,
    S_DIV_GA,
    S_MUL_A,
    S_MUL_B,
    S_CRD_HD,
    S_MUL_CA,
    S_MUL_SB,
    S_MUL_SA,
    S_MUL_CB,
    S_MUL_V,
    S_DIV_V,
    S_DONE
  } ddo_state_e;

  // request to the multiply / divide unit
  typedef struct packed {
    logic       start;
    ddo_md_op_e op;
  } ddo_md_req_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } ddo_unit_sts_t;

  // cordic arctangent table, 32-bit binary angle
  function automatic logic [31:0] atan_bam(input logic [CD_IDX_W-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/ddo_in_if.sv -----
// ----------------------------------------------------------------------------
// ddo_in_if
// Wheel sample channel: valid / ready handshake with encoder counts and stamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddo_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_count;
  logic [15:0] right_count;
  logic [15:0] stamp_ms;

  modport source (output valid, left_count, right_count, stamp_ms, input ready);
  modport sink   (input valid, left_count, right_count, stamp_ms, output ready);
endinterface

`default_nettype wire

// ----- design/ddo_out_if.sv -----
// ----------------------------------------------------------------------------
// ddo_out_if
// Pose result channel: valid / ready handshake with pose and speed.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_heading;
  logic signed [31:0] forward_speed;
  logic               pose_valid;

  modport source (output valid, pose_x, pose_y, pose_heading, forward_speed, pose_valid,
                  input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, forward_speed, pose_valid,
                  output ready);
endinterface

`default_nettype wire

// ----- design/ddo_muldiv.sv -----
// ----------------------------------------------------------------------------
// ddo_muldiv
// Shared iterative 64-bit unit: wrapping multiply, 16 multiplier bits a step,
// and truncating signed divide, one restoring step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_muldiv
  import ddo_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ddo_md_req_t              req_i,
  input  logic signed [WORD_W-1:0] a_i,
  input  logic signed [WORD_W-1:0] b_i,
  output ddo_unit_sts_t            sts_o,
  output logic signed [WORD_W-1:0] res_o
);

  localparam int DIGIT_W   = 16;
  localparam int MUL_STEPS = WORD_W / DIGIT_W;
  localparam int DIV_STEPS = WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  ddo_md_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [WORD_W-1:0] rem_q;
  logic [WORD_W-1:0] res_q;
  logic              neg_q;
  logic              done_q;

  logic [WORD_W+DIGIT_W-1:0] pp;
  logic [WORD_W:0]           trial;
  logic [WORD_W-1:0]         a_mag;
  logic [WORD_W-1:0]         b_mag;
  logic                      mul_last;
  logic                      div_last;

  // partial product and restoring trial subtract
  assign pp       = {{DIGIT_W{1'b0}}, a_q} * {{WORD_W{1'b0}}, b_q[DIGIT_W-1:0]};
  assign trial    = {rem_q, a_q[WORD_W-1]} - {1'b0, b_q};
  assign a_mag    = a_i[WORD_W-1] ? (WORD_W'(0) - a_i) : a_i;
  assign b_mag    = b_i[WORD_W-1] ? (WORD_W'(0) - b_i) : b_i;
  assign mul_last = (cnt_q == CNT_W'(MUL_STEPS - 1));
  assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.op == MD_OP_MUL) ? MD_MUL : MD_DIV;
        end
      end
      MD_MUL: if (mul_last) state_d = MD_IDLE;
      MD_DIV: if (div_last) state_d = MD_FIX;
      MD_FIX: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    sts_o.busy = (state_q != MD_IDLE) || done_q;
    sts_o.done = done_q;
    res_o      = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == MD_MUL) && mul_last) || (state_q == MD_FIX);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        cnt_q <= '0;
        rem_q <= '0;
        if (req_i.start) begin
          if (req_i.op == MD_OP_MUL) begin
            a_q   <= a_i;
            b_q   <= b_i;
            res_q <= '0;
          end else begin
            a_q   <= a_mag;
            b_q   <= b_mag;
            neg_q <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
          end
        end
      end
      MD_MUL: begin
        res_q <= res_q + pp[WORD_W-1:0];
        a_q   <= a_q << DIGIT_W;
        b_q   <= b_q >> DIGIT_W;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      MD_DIV: begin
        if (!trial[WORD_W]) begin
          rem_q <= trial[WORD_W-1:0];
          a_q   <= {a_q[WORD_W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[WORD_W-2:0], a_q[WORD_W-1]};
          a_q   <= {a_q[WORD_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      MD_FIX: res_q <= neg_q ? (WORD_W'(0) - a_q) : a_q;
      default: res_q <= res_q;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/ddo_cordic.sv -----
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode cordic: sine and cosine of a 32-bit binary angle,
// Q30, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31:0]            angle_i,
  output ddo_unit_sts_t          sts_o,
  output logic signed [CD_W-1:0] cos_o,
  output logic signed [CD_W-1:0] sin_o
);

  localparam int STEPS = (CORDIC_STEPS < CD_MAX) ? CORDIC_STEPS : CD_MAX;

  ddo_cd_state_e state_q, state_d;
  logic [CD_IDX_W-1:0]   cnt_q;
  logic signed [CD_W-1:0] x_q, y_q, z_q;
  logic                   flip_q;

  logic [31:0]            ang_fold;
  logic                   flip;
  logic signed [CD_W-1:0] sx, sy, at;
  logic                   last;

  function automatic logic ang_fold_msb(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h40000000;
    return t[31];
  endfunction

  // fold into [-pi/2, pi/2)
  assign flip     = ang_fold_msb(angle_i);
  assign ang_fold = flip ? (angle_i + 32'h80000000) : angle_i;
  assign sx       = y_q >>> cnt_q;
  assign sy       = x_q >>> cnt_q;
  assign at       = {{(CD_W-32){1'b0}}, atan_bam(cnt_q)};
  assign last     = (cnt_q == CD_IDX_W'(STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CD_IDLE: if (start_i) state_d = CD_RUN;
      CD_RUN:  if (last) state_d = CD_FIX;
      CD_FIX:  state_d = CD_DONE;
      CD_DONE: state_d = CD_IDLE;
      default: state_d = CD_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    sts_o.busy = (state_q != CD_IDLE);
    sts_o.done = (state_q == CD_DONE);
    cos_o      = x_q;
    sin_o      = y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // micro-rotations
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CD_IDLE: begin
        cnt_q  <= '0;
        x_q    <= CD_GAIN_Q30;
        y_q    <= '0;
        z_q    <= {{(CD_W-32){ang_fold[31]}}, ang_fold};
        flip_q <= flip;
      end
      CD_RUN: begin
        if (!z_q[CD_W-1]) begin
          x_q <= x_q - sx;
          y_q <= y_q + sy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + sx;
          y_q <= y_q - sy;
          z_q <= z_q + at;
        end
        cnt_q <= cnt_q + CD_IDX_W'(1);
      end
      CD_FIX: begin
        if (flip_q) begin
          x_q <= -x_q;
          y_q <= -y_q;
        end
      end
      default: cnt_q <= cnt_q;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/diff_drive_odometry_core.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Differential-drive wheel odometry: pose and forward speed from encoder
// counts, sequenced over a shared multiply / divide unit and a cordic.
// ----------------------------------------------------------------------------
// One wheel sample in, one pose item out. The first sample after reset only
// primes the counts and stamp (pose_valid low, speed zero). A sample runs
// up to fourteen multiplies, one to four 64-step restoring divides and one
// or two cordic runs. in_ch.ready is high only while no sample is in work;
// a finished item waits in the output register so the next sample can be
// taken meanwhile. Configuration is to be written only while idle; the
// block itself does not enforce it.
`default_nettype none

module diff_drive_odometry_core
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ddo_in_if.sink                in_ch,
  ddo_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int H_SHIFT = 33 - POS_FRAC_BITS;

  // configuration
  logic [31:0] left_mpt_q, right_mpt_q;
  logic [15:0] wheel_base_q;
  logic [15:0] wb_eff;

  // sample state
  logic [15:0] last_left_q, last_right_q, last_stamp_q;
  logic        primed_q;
  logic [31:0] acc_x_q, acc_y_q;
  logic [15:0] heading_q;

  // work registers
  ddo_state_e state_q, state_d;
  logic                     issued_q;
  logic                     upd_q;
  logic signed [15:0]       tdl_q, tdr_q;
  logic [15:0]              el_q;
  logic signed [WORD_W-1:0] dl_q, dr_q, q_q, h_q, q2_q, t_q;
  logic signed [WORD_W-1:0] f_q, g_q, a_q, b_q, wx_q, wy_q;
  logic [31:0]              ang_q;
  logic signed [CD_W-1:0]   c30_q, s30_q;
  logic signed [TRIG_W-1:0] c_q, s_q;
  logic [31:0]              speed_q;

  // output register
  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q, out_speed_q;
  logic [15:0] out_head_q;
  logic        out_pv_q;

  // unit hookup
  ddo_md_req_t              md_req;
  ddo_unit_sts_t            md_sts, cd_sts;
  logic signed [WORD_W-1:0] md_a, md_b, md_res;
  logic                     cd_start;
  logic [31:0]              cd_angle;
  logic signed [CD_W-1:0]   cd_cos, cd_sin, cd_c_rnd, cd_s_rnd;

  logic                     in_acc, out_acc, out_load, q_small;
  logic signed [WORD_W-1:0] c_x, s_x, c30_x, s30_x;
  logic signed [WORD_W-1:0] t_mag, rcp_quo, g24_quo;
  logic [31:0]              sat_v, sat_z;
  logic [31:0]              ang_rnd;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
  assign wb_eff   = (wheel_base_q == 16'd0) ? 16'd1 : wheel_base_q;
  assign q_small  = (q_q > -64'sd1048576) && (q_q < 64'sd1048576);

  assign c_x   = {{(WORD_W-TRIG_W){c_q[TRIG_W-1]}}, c_q};
  assign s_x   = {{(WORD_W-TRIG_W){s_q[TRIG_W-1]}}, s_q};
  assign c30_x = {{(WORD_W-CD_W){c30_q[CD_W-1]}}, c30_q};
  assign s30_x = {{(WORD_W-CD_W){s30_q[CD_W-1]}}, s30_q};

  // truncating divides by 6 and 24 as reciprocal multiplies
  assign t_mag   = t_q[WORD_W-1] ? -t_q : t_q;
  assign rcp_quo = md_res >>> RCP_SHIFT;
  assign g24_quo = t_q[WORD_W-1] ? -rcp_quo : rcp_quo;

  assign cd_c_rnd = (cd_cos + 34'sd512) >>> 10;
  assign cd_s_rnd = (cd_sin + 34'sd512) >>> 10;
  assign ang_rnd  = ang_q + 32'h00008000;

  // speed saturation, divided and zero-time forms
  assign sat_v = (md_res > 64'sd2147483647)  ? 32'h7FFFFFFF :
                 (md_res < -64'sd2147483648) ? 32'h80000000 : md_res[31:0];
  assign sat_z = (wx_q > 64'sd0) ? 32'h7FFFFFFF :
                 (wx_q < 64'sd0) ? 32'h80000000 : 32'h00000000;

  ddo_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .sts_o  (md_sts),
    .res_o  (md_res)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .angle_i (cd_angle),
    .sts_o   (cd_sts),
    .cos_o   (cd_cos),
    .sin_o   (cd_sin)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_acc) state_d = primed_q ? S_MUL_DL : S_DONE;
      S_MUL_DL:   if (md_sts.done) state_d = S_MUL_DR;
      S_MUL_DR:   if (md_sts.done) state_d = S_DIV_Q;
      S_DIV_Q:    if (md_sts.done) state_d = S_MUL_ANG;
      S_MUL_ANG:  if (md_sts.done) state_d = q_small ? S_MUL_Q2 : S_CRD_ARC;
      S_MUL_Q2:   if (md_sts.done) state_d = S_MUL_CUBE;
      S_MUL_CUBE: if (md_sts.done) state_d = S_MUL_F6;
      S_MUL_F6:   if (md_sts.done) state_d = S_MUL_G24;
      S_MUL_G24:  if (md_sts.done) state_d = S_MUL_A;
      S_CRD_ARC:  if (cd_sts.done) state_d = S_DIV_FA;
      S_DIV_FA:   if (md_sts.done) state_d = S_DIV_GA;
      S_DIV_GA:   if (md_sts.done) state_d = S_MUL_A;
      S_MUL_A:    if (md_sts.done) state_d = S_MUL_B;
      S_MUL_B:    if (md_sts.done) state_d = S_CRD_HD;
      S_CRD_HD:   if (cd_sts.done) state_d = S_MUL_CA;
      S_MUL_CA:   if (md_sts.done) state_d = S_MUL_SB;
      S_MUL_SB:   if (md_sts.done) state_d = S_MUL_SA;
      S_MUL_SA:   if (md_sts.done) state_d = S_MUL_CB;
      S_MUL_CB:   if (md_sts.done) state_d = (el_q == 16'd0) ? S_DONE : S_MUL_V;
      S_MUL_V:    if (md_sts.done) state_d = S_DIV_V;
      S_DIV_V:    if (md_sts.done) state_d = S_DONE;
      S_DONE:     if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // unit requests and operands
  always_comb begin
    md_req.start = 1'b0;
    md_req.op    = MD_OP_MUL;
    md_a         = '0;
    md_b         = '0;
    cd_start     = 1'b0;
    cd_angle     = '0;
    unique case (state_q)
      S_MUL_DL: begin
        md_a = {{(WORD_W-16){tdl_q[15]}}, tdl_q};
        md_b = {{(WORD_W-32){1'b0}}, left_mpt_q};
      end
      S_MUL_DR: begin
        md_a = {{(WORD_W-16){tdr_q[15]}}, tdr_q};
        md_b = {{(WORD_W-32){1'b0}}, right_mpt_q};
      end
      S_DIV_Q: begin
        md_req.op = MD_OP_DIV;
        md_a      = (dr_q - dl_q) <<< 8;
        md_b      = {{(WORD_W-16){1'b0}}, wb_eff};
      end
      S_MUL_ANG: begin
        md_a = q_q;
        md_b = RAD24_TO_BAM32;
      end
      S_MUL_Q2: begin
        md_a = q_q;
        md_b = q_q;
      end
      S_MUL_CUBE: begin
        md_a = q2_q;
        md_b = q_q;
      end
      S_MUL_F6: begin
        md_a = q2_q;
        md_b = RCP_DIV6;
      end
      S_MUL_G24: begin
        md_a = t_mag;
        md_b = RCP_DIV24;
      end
      S_DIV_FA: begin
        md_req.op = MD_OP_DIV;
        md_a      = s30_x <<< 14;
        md_b      = q_q;
      end
      S_DIV_GA: begin
        md_req.op = MD_OP_DIV;
        md_a      = (64'sd1073741824 - c30_x) <<< 14;
        md_b      = q_q;
      end
      S_MUL_A: begin
        md_a = h_q;
        md_b = f_q;
      end
      S_MUL_B: begin
        md_a = h_q;
        md_b = g_q;
      end
      S_MUL_CA: begin
        md_a = c_x;
        md_b = a_q;
      end
      S_MUL_SB: begin
        md_a = s_x;
        md_b = b_q;
      end
      S_MUL_SA: begin
        md_a = s_x;
        md_b = a_q;
      end
      S_MUL_CB: begin
        md_a = c_x;
        md_b = b_q;
      end
      S_MUL_V: begin
        md_a = wx_q;
        md_b = 64'sd1000;
      end
      S_DIV_V: begin
        md_req.op = MD_OP_DIV;
        md_a      = t_q;
        md_b      = {{(WORD_W-16){1'b0}}, el_q};
      end
      S_CRD_ARC: begin
        cd_start = !issued_q;
        cd_angle = ang_q;
      end
      S_CRD_HD: begin
        cd_start = !issued_q;
        cd_angle = {heading_q, 16'h0000};
      end
      default: begin
        md_req.start = 1'b0;
      end
    endcase
    if ((state_q != S_IDLE) && (state_q != S_DONE) && (state_q != S_CRD_ARC) &&
        (state_q != S_CRD_HD)) begin
      md_req.start = !issued_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issued_q     <= 1'b0;
      left_mpt_q   <= LEFT_MPT_RST;
      right_mpt_q  <= RIGHT_MPT_RST;
      wheel_base_q <= WHEEL_BASE_RST;
      last_left_q  <= '0;
      last_right_q <= '0;
      last_stamp_q <= '0;
      primed_q     <= 1'b0;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
      heading_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (md_sts.done || cd_sts.done) begin
        issued_q <= 1'b0;
      end else if (md_req.start || cd_start) begin
        issued_q <= 1'b1;
      end

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LEFT_MPT:   left_mpt_q   <= cfg_data_i;
          CFG_RIGHT_MPT:  right_mpt_q  <= cfg_data_i;
          CFG_WHEEL_BASE: wheel_base_q <= cfg_data_i[15:0];
          default:        wheel_base_q <= wheel_base_q;
        endcase
      end

      if (in_acc) begin
        last_left_q  <= in_ch.left_count;
        last_right_q <= in_ch.right_count;
        last_stamp_q <= in_ch.stamp_ms;
        primed_q     <= 1'b1;
      end

      // pose update as the item enters the output register
      if (out_load) begin
        acc_x_q   <= acc_x_q + wx_q[31:0];
        acc_y_q   <= acc_y_q + wy_q[31:0];
        heading_q <= heading_q + ang_rnd[31:16];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tdl_q   <= in_ch.left_count - last_left_q;
      tdr_q   <= in_ch.right_count - last_right_q;
      el_q    <= in_ch.stamp_ms - last_stamp_q;
      upd_q   <= primed_q;
      wx_q    <= '0;
      wy_q    <= '0;
      ang_q   <= '0;
      speed_q <= '0;
    end
    if (md_sts.done) begin
      unique case (state_q)
        S_MUL_DL:   dl_q <= md_res;
        S_MUL_DR:   dr_q <= md_res;
        S_DIV_Q:    q_q  <= md_res;
        S_MUL_ANG: begin
          ang_q <= md_res[55:24];
          h_q   <= (dl_q + dr_q) >>> H_SHIFT;
        end
        S_MUL_Q2:   q2_q <= md_res >>> 24;
        S_MUL_CUBE: t_q  <= md_res >>> 24;
        S_MUL_F6:   f_q  <= (64'sd16777216 - rcp_quo + 64'sd8) >>> 4;
        S_MUL_G24:  g_q  <= ((q_q >>> 1) - g24_quo + 64'sd8) >>> 4;
        S_DIV_FA:   f_q  <= md_res;
        S_DIV_GA:   g_q  <= md_res;
        S_MUL_A:    a_q  <= md_res >>> 20;
        S_MUL_B:    b_q  <= md_res >>> 20;
        S_MUL_CA:   t_q  <= md_res;
        S_MUL_SB:   wx_q <= (t_q - md_res) >>> 20;
        S_MUL_SA:   t_q  <= md_res;
        S_MUL_CB: begin
          wy_q    <= (t_q + md_res) >>> 20;
          speed_q <= sat_z;
        end
        S_MUL_V:    t_q     <= md_res;
        S_DIV_V:    speed_q <= sat_v;
        default:    t_q     <= t_q;
      endcase
    end
    if (cd_sts.done) begin
      if (state_q == S_CRD_ARC) begin
        c30_q <= cd_cos;
        s30_q <= cd_sin;
      end else begin
        c_q <= cd_c_rnd[TRIG_W-1:0];
        s_q <= cd_s_rnd[TRIG_W-1:0];
      end
    end
    if (out_load) begin
      out_x_q     <= acc_x_q + wx_q[31:0];
      out_y_q     <= acc_y_q + wy_q[31:0];
      out_head_q  <= heading_q + ang_rnd[31:16];
      out_speed_q <= speed_q;
      out_pv_q    <= upd_q;
    end
  end

  // ports
  assign in_ch.ready          = (state_q == S_IDLE);
  assign out_ch.valid         = out_valid_q;
  assign out_ch.pose_x        = out_x_q;
  assign out_ch.pose_y        = out_y_q;
  assign out_ch.pose_heading  = out_head_q;
  assign out_ch.forward_speed = out_speed_q;
  assign out_ch.pose_valid    = out_pv_q;

`ifndef SYNTHESIS
  // a sample in work blocks the input until its item is loaded into the output register
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ch.ready)
    else $error("input ready right after a sample was taken");

  // the shared unit is only started while it is idle
  a_md_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> !md_sts.busy)
    else $error("muldiv started while busy");

  // the two iterative units never run at once
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(md_sts.busy && cd_sts.busy))
    else $error("muldiv and cordic busy together");

  // an updated pose can only follow priming
  a_valid_after_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.pose_valid) |-> primed_q)
    else $error("valid pose before priming sample");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for diff_drive_odometry_core: a directed table of wheel
// samples followed by random sample sequences under several wheel settings.
// Every accepted sample is run through an in-bench odometry predictor. Each
// pose item that comes out is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ddo_pkg::*;

  localparam int unsigned RUN_LIMIT   = 3000000;
  localparam int unsigned DRAIN_WAIT  = 600;
  localparam int          ROT_STEPS   = 16;
  localparam longint      ROT_GAIN    = 64'sd652032874;
  localparam longint      RAD_TO_BAM  = 64'sd683565276;
  localparam int          RAND_PER_PH = 215;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hd;
    logic signed [31:0] spd;
    logic               vld;
  } pose_t;

  typedef struct packed {
    logic [15:0] l;
    logic [15:0] r;
    logic [15:0] s;
    logic        pin;
    pose_t       want;
  } sample_row_t;

  typedef enum logic [1:0] {
    GAP_NONE,
    GAP_SENDER,
    GAP_RECEIVER,
    GAP_BOTH
  } gap_mode_e;

  // rotation arctangent steps, 32-bit binary angle
  localparam logic [31:0] ROT_ATAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ddo_in_if  in_ch ();
  ddo_out_if out_ch ();

  diff_drive_odometry_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // odometry state mirrored by the predictor
  logic [31:0] mpt_left, mpt_right;
  logic [15:0] base_len;
  logic [15:0] prev_left, prev_right, prev_stamp;
  logic        is_primed;
  logic [31:0] sum_x, sum_y;
  logic [15:0] cur_heading;

  pose_t       pose_q [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned tx_gap_pct, rx_gap_pct;

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // rotation-mode sine / cosine, Q30
  function automatic void rotate_angle(input logic [31:0] ang, output longint co,
                                       output longint si);
    longint x, y, z, sx, sy;
    logic [31:0] tmp;
    logic signed [31:0] zs;
    logic flip;
    tmp  = ang + 32'h40000000;
    flip = tmp[31];
    if (flip) ang = ang + 32'h80000000;
    zs = ang;
    z  = zs;
    x  = ROT_GAIN;
    y  = 0;
    for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (z >= 0) begin
        x = x - sx;
        y = y + sy;
        z = z - longint'(ROT_ATAN[i]);
      end else begin
        x = x + sx;
        y = y - sy;
        z = z + longint'(ROT_ATAN[i]);
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endfunction

  // pose update for one accepted wheel sample
  function automatic pose_t odometry_step(input logic [15:0] lc, input logic [15:0] rc,
                                          input logic [15:0] st);
    longint dl, dr, wb, q, h, f, g, a, b, c30, s30, c, s, wx, wy, v, q2, cube;
    logic signed [15:0] dtl, dtr;
    logic [63:0] prod;
    logic [31:0] ang, hd_step;
    logic [15:0] el;
    pose_t res;
    res.spd = '0;
    res.vld = 1'b0;
    if (is_primed) begin
      dtl  = lc - prev_left;
      dtr  = rc - prev_right;
      dl   = longint'(dtl) * longint'(mpt_left);
      dr   = longint'(dtr) * longint'(mpt_right);
      wb   = (base_len == 16'd0) ? 64'sd1 : longint'(base_len);
      q    = ((dr - dl) * 256) / wb;
      prod = q * RAD_TO_BAM;
      ang  = prod[55:24];
      h    = (dl + dr) >>> 17;
      if (q > -64'sd1048576 && q < 64'sd1048576) begin
        // small turn: series for the arc factors
        q2   = (q * q) >>> 24;
        cube = (q2 * q) >>> 24;
        f    = (64'sd16777216 - q2 / 6 + 8) >>> 4;
        g    = ((q >>> 1) - cube / 24 + 8) >>> 4;
      end else begin
        rotate_angle(ang, c30, s30);
        f = (s30 * 16384) / q;
        g = ((64'sd1073741824 - c30) * 16384) / q;
      end
      a = (h * f) >>> 20;
      b = (h * g) >>> 20;
      // rotate the body step by the old heading
      rotate_angle({cur_heading, 16'h0000}, c30, s30);
      c  = (c30 + 512) >>> 10;
      s  = (s30 + 512) >>> 10;
      wx = (c * a - s * b) >>> 20;
      wy = (s * a + c * b) >>> 20;
      el = st - prev_stamp;
      if (el == 16'd0) v = (wx > 0) ? 64'sd2147483647 : ((wx < 0) ? -64'sd2147483648 : 0);
      else v = (wx * 1000) / longint'(el);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res.spd     = v[31:0];
      res.vld     = 1'b1;
      sum_x       = sum_x + wx[31:0];
      sum_y       = sum_y + wy[31:0];
      hd_step     = ang + 32'h00008000;
      cur_heading = cur_heading + hd_step[31:16];
    end
    prev_left  = lc;
    prev_right = rc;
    prev_stamp = st;
    is_primed  = 1'b1;
    res.x  = sum_x;
    res.y  = sum_y;
    res.hd = cur_heading;
    return res;
  endfunction

  // offer one sample and wait for it to be taken
  task automatic send_sample(input sample_row_t row);
    pose_t p;
    in_ch.valid       <= 1'b1;
    in_ch.left_count  <= row.l;
    in_ch.right_count <= row.r;
    in_ch.stamp_ms    <= row.s;
    do @(posedge clk_i); while (!in_ch.ready);
    p = odometry_step(row.l, row.r, row.s);
    pose_q.push_back(row.pin ? row.want : p);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pose_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LEFT_MPT:   mpt_left  = data;
      CFG_RIGHT_MPT:  mpt_right = data;
      CFG_WHEEL_BASE: base_len  = data[15:0];
      default: ;
    endcase
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= rx_gap_pct);
  end

  // pose item checker
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pose_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected pose item x=%0d y=%0d hd=%0d spd=%0d vld=%0b", $time,
                 out_ch.pose_x, out_ch.pose_y, out_ch.pose_heading, out_ch.forward_speed,
                 out_ch.pose_valid);
      end else begin
        e = pose_q.pop_front();
        if (e.x !== out_ch.pose_x || e.y !== out_ch.pose_y || e.hd !== out_ch.pose_heading ||
            e.spd !== out_ch.forward_speed || e.vld !== out_ch.pose_valid) begin
          fail_cnt++;
          $display("%0t: pose mismatch exp x=%0d y=%0d hd=%0d spd=%0d vld=%0b", $time,
                   e.x, e.y, e.hd, e.spd, e.vld);
          $display("%0t:                act x=%0d y=%0d hd=%0d spd=%0d vld=%0b", $time,
                   out_ch.pose_x, out_ch.pose_y, out_ch.pose_heading, out_ch.forward_speed,
                   out_ch.pose_valid);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // directed samples, default wheel settings
  sample_row_t dir_rows [] = '{
    '{16'd0,     16'd0,     16'd0,     1'b1, '{32'sd0, 32'sd0, 16'sd0, 32'sd0, 1'b0}},
    '{16'd0,     16'd0,     16'd0,     1'b1, '{32'sd0, 32'sd0, 16'sd0, 32'sd0, 1'b1}},
    '{16'd100,   16'd100,   16'd20,    1'b0, '0},
    '{16'd50,    16'd50,    16'd40,    1'b0, '0},
    '{16'd250,   16'd150,   16'd60,    1'b0, '0},
    '{16'd1250,  16'd150,   16'd80,    1'b0, '0},
    '{16'd1250,  16'd150,   16'd80,    1'b0, '0},
    '{16'd1350,  16'd1400,  16'd80,    1'b0, '0},
    '{16'hFFF0,  16'h0010,  16'd100,   1'b0, '0},
    '{16'h7FF0,  16'h8010,  16'hFFFF,  1'b0, '0},
    '{16'hFFF0,  16'h0010,  16'h0005,  1'b0, '0},
    '{16'h0000,  16'hFFFF,  16'h0100,  1'b0, '0},
    '{16'hFFFF,  16'h0000,  16'hFFFE,  1'b0, '0},
    '{16'h8000,  16'h7FFF,  16'h0200,  1'b0, '0},
    '{16'h8400,  16'h7BFF,  16'h0210,  1'b0, '0},
    '{16'h8800,  16'h77FF,  16'h0220,  1'b0, '0},
    '{16'h8C00,  16'h73FF,  16'h0230,  1'b0, '0},
    '{16'h9000,  16'h6FFF,  16'h0240,  1'b0, '0},
    '{16'h9000,  16'h6FFF,  16'h0241,  1'b0, '0},
    '{16'h9064,  16'h7063,  16'h0250,  1'b0, '0}
  };

  // stimulus
  initial begin
    sample_row_t row;
    logic [15:0] gl, gr, gs;
    int unsigned pick;
    int signed   step;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.left_count  = '0;
    in_ch.right_count = '0;
    in_ch.stamp_ms    = '0;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    mpt_left    = LEFT_MPT_RST;
    mpt_right   = RIGHT_MPT_RST;
    base_len    = WHEEL_BASE_RST;
    prev_left   = '0;
    prev_right  = '0;
    prev_stamp  = '0;
    is_primed   = 1'b0;
    sum_x       = '0;
    sum_y       = '0;
    cur_heading = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_sample(dir_rows[i]);
    gl = prev_left;
    gr = prev_right;
    gs = prev_stamp;

    for (int ph = 0; ph < 5; ph++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      // wheel settings for this phase
      case (ph)
        0: begin
          cfg_write(CFG_LEFT_MPT, LEFT_MPT_RST);
          cfg_write(CFG_RIGHT_MPT, RIGHT_MPT_RST);
          cfg_write(CFG_WHEEL_BASE, 32'(WHEEL_BASE_RST));
        end
        1: begin
          cfg_write(CFG_LEFT_MPT, 32'hFFFFFFFF);
          cfg_write(CFG_RIGHT_MPT, 32'hFFFFFFFF);
          cfg_write(CFG_WHEEL_BASE, 32'd1);
        end
        2: begin
          cfg_write(CFG_LEFT_MPT, 32'd0);
          cfg_write(CFG_RIGHT_MPT, 32'd0);
          cfg_write(CFG_WHEEL_BASE, 32'd65535);
          cfg_write(CFG_SPARE, $urandom);
        end
        3: begin
          cfg_write(CFG_LEFT_MPT, $urandom);
          cfg_write(CFG_RIGHT_MPT, $urandom);
          cfg_write(CFG_WHEEL_BASE, 32'd0);
        end
        default: begin
          cfg_write(CFG_LEFT_MPT, $urandom_range(2000000, 100000));
          cfg_write(CFG_RIGHT_MPT, $urandom_range(2000000, 100000));
          cfg_write(CFG_WHEEL_BASE, {$urandom_range(65535, 1)} | 32'hFFFF0000);
        end
      endcase
      cfg_we_i <= 1'b0;
      case (gap_mode_e'(ph % 4))
        GAP_NONE:     begin tx_gap_pct = 0;  rx_gap_pct = 0;  end
        GAP_SENDER:   begin tx_gap_pct = 78; rx_gap_pct = 0;  end
        GAP_RECEIVER: begin tx_gap_pct = 0;  rx_gap_pct = 78; end
        default:      begin tx_gap_pct = 16; rx_gap_pct = 16; end
      endcase

      // mostly plausible motion, some arbitrary jumps
      for (int n = 0; n < RAND_PER_PH; n++) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          gl = $urandom;
          gr = $urandom;
          gs = $urandom;
        end else begin
          step = $signed($urandom_range(600)) - 300;
          gl   = gl + 16'(step);
          if (pick < 35) gr = gr + 16'(step);
          else gr = gr + 16'($signed($urandom_range(600)) - 300);
          gs = gs + ((pick < 40) ? 16'd0 : 16'($urandom_range(100)));
        end
        row = '{gl, gr, gs, 1'b0, '0};
        send_sample(row);
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
